FILE: src/cowbt_pkg.sv
`timescale 1ns / 1ps
// Copy-on-write block tracker: shared types, codes and result builder.
// No dependencies; imported by cowbt_cmp, cowbt_ctrl and the top module.
package cowbt_pkg;

    localparam logic [1:0] ACT_WRITE   = 2'd0;
    localparam logic [1:0] ACT_RECOVER = 2'd1;
    localparam logic [1:0] ACT_FLUSH   = 2'd2;

    localparam logic [1:0] KIND_WRITE   = 2'd0;
    localparam logic [1:0] KIND_RUN     = 2'd1;
    localparam logic [1:0] KIND_NOTHING = 2'd2;
    localparam logic [1:0] KIND_FLUSH   = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_BEYOND = 2'd2;

    localparam logic [1:0] CFG_USE_BITMAP   = 2'd0;
    localparam logic [1:0] CFG_LOG_CAPACITY = 2'd1;

    localparam logic       USE_BITMAP_RESET   = 1'b1;
    localparam logic [5:0] LOG_CAPACITY_RESET = 6'd32;
    localparam logic [5:0] MAX_RUNS           = 6'd32;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] block_pos;
        logic [31:0] recover_limit;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  status;
        logic        must_save;
        logic [4:0]  log_slot;
        logic [31:0] run_first;
        logic [31:0] run_last;
        logic        last_result;
    } res_t;

    typedef struct packed {
        logic       use_bitmap;
        logic [5:0] log_capacity;
    } cfg_t;

    typedef struct packed {
        logic match;     // entry equals block position
        logic le_limit;  // entry at or below recover limit
        logic adjacent;  // entry follows the open run's last position
    } cmp_res_t;

    function automatic res_t make_res(
        input logic [1:0]  kind,
        input logic [1:0]  status,
        input logic        must_save,
        input logic [4:0]  log_slot,
        input logic [31:0] run_first,
        input logic [31:0] run_last,
        input logic        last_result
    );
        res_t r;
        r.kind        = kind;
        r.status      = status;
        r.must_save   = must_save;
        r.log_slot    = log_slot;
        r.run_first   = run_first;
        r.run_last    = run_last;
        r.last_result = last_result;
        return r;
    endfunction

endpackage

FILE: src/cowbt_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module cowbt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

FILE: src/cowbt_cmp.sv
`timescale 1ns / 1ps
// Shared compare unit: tests one log entry against the key, limit and open run.
// Depends on cowbt_pkg.
module cowbt_cmp (
    input  logic [31:0]         data,
    input  logic [31:0]         key,
    input  logic [31:0]         limit,
    input  logic [31:0]         run_last,
    output cowbt_pkg::cmp_res_t res
);
    import cowbt_pkg::*;

    logic [32:0] next_pos;

    // 33-bit successor so that a run ending at the top position never extends
    assign next_pos     = {1'b0, run_last} + 33'd1;
    assign res.match    = (data == key);
    assign res.le_limit = (data <= limit);
    assign res.adjacent = ({1'b0, data} == next_pos);
endmodule

FILE: src/cowbt_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the block tracker: command decode, log walk, run coalescing,
// bitmap read-modify-write and clearing sweep. Depends on cowbt_pkg, cowbt_cmp.
module cowbt_ctrl #(
    parameter int LOG_DEPTH  = 32,
    parameter int MAP_BLOCKS = 65536
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  cowbt_pkg::cmd_t         cmd,
    input  cowbt_pkg::cfg_t         cfg,
    output cowbt_pkg::res_t         result,
    output logic                    result_valid,
    output logic                    log_wr_en,
    output logic [(LOG_DEPTH > 1 ? $clog2(LOG_DEPTH) : 1)-1:0] log_wr_addr,
    output logic [31:0]             log_wr_data,
    output logic                    log_rd_en,
    output logic [(LOG_DEPTH > 1 ? $clog2(LOG_DEPTH) : 1)-1:0] log_rd_addr,
    input  logic [31:0]             log_rd_data,
    output logic                    map_wr_en,
    output logic [((MAP_BLOCKS + 63) / 64 > 1 ? $clog2((MAP_BLOCKS + 63) / 64) : 1)-1:0]
                                    map_wr_addr,
    output logic [63:0]             map_wr_data,
    output logic                    map_rd_en,
    output logic [((MAP_BLOCKS + 63) / 64 > 1 ? $clog2((MAP_BLOCKS + 63) / 64) : 1)-1:0]
                                    map_rd_addr,
    input  logic [63:0]             map_rd_data
);
    import cowbt_pkg::*;

    localparam int IDX_W    = LOG_DEPTH > 1 ? $clog2(LOG_DEPTH) : 1;
    localparam int MAP_ROWS = (MAP_BLOCKS + 63) / 64;
    localparam int ROW_W    = MAP_ROWS > 1 ? $clog2(MAP_ROWS) : 1;
    localparam int CW       = (IDX_W + 2 > 7) ? IDX_W + 2 : 7;

    localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(MAP_ROWS - 1);
    localparam logic [CW-1:0]    DEPTH_CAP = CW'(LOG_DEPTH);
    localparam logic [31:0]      MAP_LIMIT = 32'(MAP_BLOCKS);

    typedef enum logic [5:0] {
        S_CLEAR   = 6'b000001,
        S_IDLE    = 6'b000010,
        S_WALK    = 6'b000100,
        S_DECIDE  = 6'b001000,
        S_REC_END = 6'b010000,
        S_REC_OUT = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [IDX_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  proc_idx_reg, proc_idx_next;
    logic              rd_vld_reg, rd_vld_next;
    logic              found_reg, found_next;
    logic [ROW_W-1:0]  clr_row_reg, clr_row_next;
    logic              flush_reg, flush_next;
    logic              open_reg, open_next;
    logic [31:0]       first_reg, first_next;
    logic [31:0]       last_reg, last_next;
    logic [IDX_W-1:0]  start_reg, start_next;
    logic [5:0]        nruns_reg, nruns_next;
    logic              pend_vld_reg, pend_vld_next;
    logic [31:0]       pend_first_reg, pend_first_next;
    logic [31:0]       pend_last_reg, pend_last_next;
    logic [IDX_W-1:0]  pend_start_reg, pend_start_next;
    res_t              res_reg, res_next;
    logic              res_vld_reg, res_vld_next;

    cmp_res_t          cmp;
    logic              issue;
    logic              produce;
    logic              saved;
    logic              full;
    logic              extend;
    logic [CW-1:0]     cap_eff;

    cowbt_cmp u_cmp (
        .data     (log_rd_data),
        .key      (cmd_reg.block_pos),
        .limit    (cmd_reg.recover_limit),
        .run_last (last_reg),
        .res      (cmp)
    );

    assign cap_eff = (CW'(cfg.log_capacity) > DEPTH_CAP) ? DEPTH_CAP : CW'(cfg.log_capacity);
    assign full    = (CW'(count_reg) + CW'(1)) >= cap_eff;
    assign saved   = cfg.use_bitmap ? map_rd_data[cmd_reg.block_pos[5:0]] : found_reg;
    assign extend  = open_reg && cmp.le_limit && cmp.adjacent;

    assign log_wr_addr = count_reg;
    assign log_wr_data = cmd_reg.block_pos;
    assign log_rd_addr = idx_reg;

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        proc_idx_next   = proc_idx_reg;
        rd_vld_next     = rd_vld_reg;
        found_next      = found_reg;
        clr_row_next    = clr_row_reg;
        flush_next      = flush_reg;
        open_next       = open_reg;
        first_next      = first_reg;
        last_next       = last_reg;
        start_next      = start_reg;
        nruns_next      = nruns_reg;
        pend_vld_next   = pend_vld_reg;
        pend_first_next = pend_first_reg;
        pend_last_next  = pend_last_reg;
        pend_start_next = pend_start_reg;
        res_next        = '0;
        res_vld_next    = 1'b0;
        issue           = 1'b0;
        produce         = 1'b0;
        log_wr_en       = 1'b0;
        log_rd_en       = 1'b0;
        map_wr_en       = 1'b0;
        map_wr_addr     = ROW_W'(cmd_reg.block_pos >> 6);
        map_wr_data     = map_rd_data | (64'd1 << cmd_reg.block_pos[5:0]);
        map_rd_en       = 1'b0;
        map_rd_addr     = ROW_W'(cmd.block_pos >> 6);

        case (state_reg)
            S_CLEAR:
            begin
                map_wr_en   = 1'b1;
                map_wr_addr = clr_row_reg;
                map_wr_data = '0;
                if (clr_row_reg == ROW_LAST)
                begin
                    state_next = S_IDLE;
                    if (flush_reg)
                    begin
                        res_next     = make_res(KIND_FLUSH, ST_OK, 1'b0, 5'd0, 32'd0, 32'd0,
                                                1'b1);
                        res_vld_next = 1'b1;
                        flush_next   = 1'b0;
                    end
                end
                else
                begin
                    clr_row_next = clr_row_reg + ROW_W'(1);
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next    = cmd;
                    idx_next    = '0;
                    rd_vld_next = 1'b0;
                    case (cmd.action)
                        ACT_WRITE:
                        begin
                            found_next = 1'b0;
                            if (!cfg.use_bitmap)
                            begin
                                state_next = S_WALK;
                            end
                            else if (cmd.block_pos >= MAP_LIMIT)
                            begin
                                res_next     = make_res(KIND_WRITE, ST_BEYOND, 1'b0, 5'd0,
                                                        32'd0, 32'd0, 1'b1);
                                res_vld_next = 1'b1;
                            end
                            else
                            begin
                                map_rd_en  = 1'b1;
                                state_next = S_DECIDE;
                            end
                        end
                        ACT_RECOVER:
                        begin
                            open_next     = 1'b0;
                            nruns_next    = '0;
                            pend_vld_next = 1'b0;
                            state_next    = S_WALK;
                        end
                        ACT_FLUSH:
                        begin
                            count_next   = '0;
                            clr_row_next = '0;
                            flush_next   = 1'b1;
                            state_next   = S_CLEAR;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_WALK:
            begin
                // one log read issued per cycle, compared on the registered read data in the next cycle
                issue = (idx_reg != count_reg);
                if (issue)
                begin
                    log_rd_en     = 1'b1;
                    idx_next      = idx_reg + IDX_W'(1);
                    proc_idx_next = idx_reg;
                end
                rd_vld_next = issue;
                if (rd_vld_reg)
                begin
                    if (cmd_reg.action == ACT_WRITE)
                    begin
                        if (cmp.match)
                        begin
                            found_next = 1'b1;
                        end
                    end
                    else if (extend)
                    begin
                        last_next = log_rd_data;
                    end
                    else
                    begin
                        produce   = open_reg && (nruns_reg < MAX_RUNS);
                        open_next = cmp.le_limit;
                        if (cmp.le_limit)
                        begin
                            first_next = log_rd_data;
                            last_next  = log_rd_data;
                            start_next = proc_idx_reg;
                        end
                    end
                end
                if (!issue && !rd_vld_reg)
                begin
                    state_next = (cmd_reg.action == ACT_WRITE) ? S_DECIDE : S_REC_END;
                end
            end

            S_DECIDE:
            begin
                state_next   = S_IDLE;
                res_vld_next = 1'b1;
                if (saved)
                begin
                    res_next = make_res(KIND_WRITE, ST_OK, 1'b0, 5'd0, 32'd0, 32'd0, 1'b1);
                end
                else if (full)
                begin
                    res_next = make_res(KIND_WRITE, ST_FULL, 1'b0, 5'd0, 32'd0, 32'd0, 1'b1);
                end
                else
                begin
                    log_wr_en  = 1'b1;
                    map_wr_en  = cfg.use_bitmap;
                    count_next = count_reg + IDX_W'(1);
                    res_next   = make_res(KIND_WRITE, ST_OK, 1'b1, 5'(count_reg), 32'd0, 32'd0,
                                          1'b1);
                end
            end

            S_REC_END:
            begin
                produce    = open_reg && (nruns_reg < MAX_RUNS);
                state_next = S_REC_OUT;
            end

            S_REC_OUT:
            begin
                state_next   = S_IDLE;
                res_vld_next = 1'b1;
                if (pend_vld_reg)
                begin
                    res_next = make_res(KIND_RUN, ST_OK, 1'b0, 5'(pend_start_reg),
                                        pend_first_reg, pend_last_reg, 1'b1);
                end
                else
                begin
                    res_next = make_res(KIND_NOTHING, ST_OK, 1'b0, 5'd0, 32'd0, 32'd0, 1'b1);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // a closed run is held back one step so the final one can carry last_result
        if (produce)
        begin
            if (pend_vld_reg)
            begin
                res_next     = make_res(KIND_RUN, ST_OK, 1'b0, 5'(pend_start_reg),
                                        pend_first_reg, pend_last_reg, 1'b0);
                res_vld_next = 1'b1;
            end
            pend_vld_next   = 1'b1;
            pend_first_next = first_reg;
            pend_last_next  = last_reg;
            pend_start_next = start_reg;
            nruns_next      = nruns_reg + 6'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            count_reg    <= '0;
            idx_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            found_reg    <= 1'b0;
            clr_row_reg  <= '0;
            flush_reg    <= 1'b0;
            open_reg     <= 1'b0;
            nruns_reg    <= '0;
            pend_vld_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            idx_reg      <= idx_next;
            rd_vld_reg   <= rd_vld_next;
            found_reg    <= found_next;
            clr_row_reg  <= clr_row_next;
            flush_reg    <= flush_next;
            open_reg     <= open_next;
            nruns_reg    <= nruns_next;
            pend_vld_reg <= pend_vld_next;
            res_vld_reg  <= res_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        proc_idx_reg   <= proc_idx_next;
        first_reg      <= first_next;
        last_reg       <= last_next;
        start_reg      <= start_next;
        pend_first_reg <= pend_first_next;
        pend_last_reg  <= pend_last_next;
        pend_start_reg <= pend_start_next;
        res_reg        <= res_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign result       = res_reg;
    assign result_valid = res_vld_reg;
endmodule

FILE: src/copy_on_write_block_tracker_top.sv
`timescale 1ns / 1ps
// Copy-on-write block tracker top: config registers, log RAM, bitmap RAM, sequencer.
// Depends on cowbt_pkg, cowbt_ram, cowbt_ctrl (which uses cowbt_cmp).
// Write, bitmap mode: bitmap row read-modify-write, busy while the row is updated.
// Write, list mode: walks the log entries, then decides and registers the result.
// Recover: one log RAM read per cycle; runs go out as they close, the final one at the end.
// Flush: clears the bitmap one 64-bit row per cycle, then gives the result.
// Reset runs the same clear with busy high; results cannot stall.
module copy_on_write_block_tracker_top #(
    parameter int LOG_DEPTH  = 32,
    parameter int MAP_BLOCKS = 65536
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  cowbt_pkg::cmd_t cmd,
    output cowbt_pkg::res_t result,
    output logic            result_valid,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [1:0]      cfg_index,
    input  logic [5:0]      cfg_data
);
    import cowbt_pkg::*;

    localparam int IDX_W    = LOG_DEPTH > 1 ? $clog2(LOG_DEPTH) : 1;
    localparam int MAP_ROWS = (MAP_BLOCKS + 63) / 64;
    localparam int ROW_W    = MAP_ROWS > 1 ? $clog2(MAP_ROWS) : 1;

    logic             use_bitmap_reg, use_bitmap_next;
    logic [5:0]       log_capacity_reg, log_capacity_next;
    cfg_t             cfg;

    logic             log_wr_en;
    logic [IDX_W-1:0] log_wr_addr;
    logic [31:0]      log_wr_data;
    logic             log_rd_en;
    logic [IDX_W-1:0] log_rd_addr;
    logic [31:0]      log_rd_data;
    logic             map_wr_en;
    logic [ROW_W-1:0] map_wr_addr;
    logic [63:0]      map_wr_data;
    logic             map_rd_en;
    logic [ROW_W-1:0] map_rd_addr;
    logic [63:0]      map_rd_data;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        use_bitmap_next   = use_bitmap_reg;
        log_capacity_next = log_capacity_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_USE_BITMAP:   use_bitmap_next   = cfg_data[0];
                CFG_LOG_CAPACITY: log_capacity_next = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_bitmap_reg   <= USE_BITMAP_RESET;
            log_capacity_reg <= LOG_CAPACITY_RESET;
        end
        else
        begin
            use_bitmap_reg   <= use_bitmap_next;
            log_capacity_reg <= log_capacity_next;
        end
    end

    assign cfg.use_bitmap   = use_bitmap_reg;
    assign cfg.log_capacity = log_capacity_reg;

    cowbt_ram #(
        .WIDTH (32),
        .DEPTH (LOG_DEPTH)
    ) u_log_ram (
        .clk     (clk),
        .wr_en   (log_wr_en),
        .wr_addr (log_wr_addr),
        .wr_data (log_wr_data),
        .rd_en   (log_rd_en),
        .rd_addr (log_rd_addr),
        .rd_data (log_rd_data)
    );

    cowbt_ram #(
        .WIDTH (64),
        .DEPTH (MAP_ROWS)
    ) u_map_ram (
        .clk     (clk),
        .wr_en   (map_wr_en),
        .wr_addr (map_wr_addr),
        .wr_data (map_wr_data),
        .rd_en   (map_rd_en),
        .rd_addr (map_rd_addr),
        .rd_data (map_rd_data)
    );

    cowbt_ctrl #(
        .LOG_DEPTH  (LOG_DEPTH),
        .MAP_BLOCKS (MAP_BLOCKS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .cfg          (cfg),
        .result       (result),
        .result_valid (result_valid),
        .log_wr_en    (log_wr_en),
        .log_wr_addr  (log_wr_addr),
        .log_wr_data  (log_wr_data),
        .log_rd_en    (log_rd_en),
        .log_rd_addr  (log_rd_addr),
        .log_rd_data  (log_rd_data),
        .map_wr_en    (map_wr_en),
        .map_wr_addr  (map_wr_addr),
        .map_wr_data  (map_wr_data),
        .map_rd_en    (map_rd_en),
        .map_rd_addr  (map_rd_addr),
        .map_rd_data  (map_rd_data)
    );
endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Testbench for copy_on_write_block_tracker_top: directed and random command streams,
// each result checked against a tracker model held in the bench. Depends on cowbt_pkg.
module testbench;
    import cowbt_pkg::*;

    localparam int          TRACK_DEPTH    = 32;
    localparam int          TRACK_MAX_RUNS = 32;
    localparam logic [31:0] MAP_LIMIT      = 32'd65536;
    localparam logic [1:0]  ACT_IGNORED    = 2'd3;
    localparam logic [1:0]  CFG_NO_REG     = 2'd3;
    localparam int          SETTLE_CYCLES  = 40;
    localparam int          CYCLE_LIMIT    = 600000;
    localparam int          PHASE_ITEMS    = 58;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       start        = 1'b0;
    logic       busy;
    cmd_t       cmd          = '0;
    res_t       result;
    logic       result_valid;
    logic       cfg_valid    = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index    = '0;
    logic [5:0] cfg_data     = '0;

    // tracker model: save log, saved-block bitmap, register copies
    logic [31:0]   saved_pos [TRACK_DEPTH];
    int            save_count     = 0;
    bit [65535:0]  saved_bits     = '0;
    bit            mdl_use_bitmap = 1'b1;
    logic [5:0]    mdl_capacity   = 6'd32;

    res_t        expected_results [$];
    logic [31:0] prev_rand_pos   = '0;
    bit          quiet_run       = 1'b0;
    int          sent_items      = 0;
    int          checked_results = 0;
    int          cfg_writes      = 0;
    int          error_count     = 0;
    int          cycle_count     = 0;

    copy_on_write_block_tracker_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result       (result),
        .result_valid (result_valid),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------- model

    function automatic res_t blank_result(logic [1:0] kind);
        res_t r;
        r             = '0;
        r.kind        = kind;
        r.last_result = 1'b1;
        return r;
    endfunction

    task automatic predict_write(logic [31:0] pos);
        int   cap_eff;
        bit   hit;
        res_t r;
        cap_eff = (int'(mdl_capacity) > TRACK_DEPTH) ? TRACK_DEPTH : int'(mdl_capacity);
        r       = blank_result(KIND_WRITE);
        hit     = 1'b0;
        if (mdl_use_bitmap)
            hit = (pos < MAP_LIMIT) && saved_bits[pos[15:0]];
        else
            for (int i = 0; i < save_count; i++)
                if (saved_pos[i] == pos)
                    hit = 1'b1;
        if (mdl_use_bitmap && pos >= MAP_LIMIT)
            r.status = ST_BEYOND;
        else if (!hit)
        begin
            if (save_count + 1 >= cap_eff)
                r.status = ST_FULL;
            else
            begin
                r.must_save           = 1'b1;
                r.log_slot            = 5'(save_count);
                saved_pos[save_count] = pos;
                if (mdl_use_bitmap)
                    saved_bits[pos[15:0]] = 1'b1;
                save_count++;
            end
        end
        expected_results.push_back(r);
    endtask

    // runs are held back one step so the final one can carry last_result
    task automatic predict_recover(logic [31:0] lim);
        int          runs;
        bit          open;
        bit          held;
        logic [31:0] pos;
        logic [31:0] first;
        logic [31:0] last;
        int          first_slot;
        res_t        run;
        res_t        r;
        runs       = 0;
        open       = 1'b0;
        held       = 1'b0;
        first      = '0;
        last       = '0;
        first_slot = 0;
        run        = '0;
        for (int i = 0; i <= save_count; i++)
        begin
            pos = (i < save_count) ? saved_pos[i] : '0;
            if (i < save_count && open && pos <= lim && {1'b0, pos} == {1'b0, last} + 33'd1)
                last = pos;
            else
            begin
                if (open && runs < TRACK_MAX_RUNS)
                begin
                    if (held)
                        expected_results.push_back(run);
                    r           = blank_result(KIND_RUN);
                    r.last_result = 1'b0;
                    r.log_slot  = 5'(first_slot);
                    r.run_first = first;
                    r.run_last  = last;
                    run         = r;
                    held        = 1'b1;
                    runs++;
                end
                open = (i < save_count) && (pos <= lim);
                if (open)
                begin
                    first      = pos;
                    last       = pos;
                    first_slot = i;
                end
            end
        end
        if (held)
        begin
            run.last_result = 1'b1;
            expected_results.push_back(run);
        end
        else
            expected_results.push_back(blank_result(KIND_NOTHING));
    endtask

    task automatic predict_cmd(cmd_t c);
        case (c.action)
            ACT_WRITE:   predict_write(c.block_pos);
            ACT_RECOVER: predict_recover(c.recover_limit);
            ACT_FLUSH:
            begin
                save_count = 0;
                saved_bits = '0;
                expected_results.push_back(blank_result(KIND_FLUSH));
            end
            default: ;
        endcase
    endtask

    // -------------------------------------------------------------- checker

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            error_count++;
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        res_t want;
        if (rst_n && result_valid === 1'b1)
        begin
            if (expected_results.size() == 0)
            begin
                error_count++;
                $display("%0t ns: unexpected result, expected none, actual %h",
                         $time, result);
            end
            else
            begin
                want = expected_results.pop_front();
                compare_field("kind",        32'(want.kind),        32'(result.kind));
                compare_field("status",      32'(want.status),      32'(result.status));
                compare_field("must_save",   32'(want.must_save),   32'(result.must_save));
                compare_field("log_slot",    32'(want.log_slot),    32'(result.log_slot));
                compare_field("run_first",   want.run_first,        result.run_first);
                compare_field("run_last",    want.run_last,         result.run_last);
                compare_field("last_result", 32'(want.last_result), 32'(result.last_result));
                checked_results++;
            end
        end
    end

    // --------------------------------------------------------------- driver

    // start stays high after a transfer; the next call either retargets or drops it
    task automatic send_cmd(cmd_t c);
        if (!quiet_run && $urandom_range(99) < 11)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        cmd   <= c;
        start <= 1'b1;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        predict_cmd(c);
        if (c.action != ACT_IGNORED)
            sent_items++;
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [5:0] data);
        wait_idle();
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cfg_writes++;
        case (idx)
            CFG_USE_BITMAP:   mdl_use_bitmap = data[0];
            CFG_LOG_CAPACITY: mdl_capacity   = data;
            default: ;
        endcase
    endtask

    function automatic cmd_t make_cmd(logic [1:0] action, logic [31:0] pos, logic [31:0] lim);
        cmd_t c;
        c.action        = action;
        c.block_pos     = pos;
        c.recover_limit = lim;
        return c;
    endfunction

    task automatic send_write(logic [31:0] pos);
        send_cmd(make_cmd(ACT_WRITE, pos, $urandom));
    endtask

    task automatic send_recover(logic [31:0] lim);
        send_cmd(make_cmd(ACT_RECOVER, $urandom, lim));
    endtask

    task automatic send_flush();
        send_cmd(make_cmd(ACT_FLUSH, $urandom, $urandom));
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_defaults();
        wait_idle();  // bitmap clear after reset
        send_recover(32'hFFFF_FFFF);   // empty log
        send_write(32'd0);
        send_write(32'd0);             // already saved
        send_write(32'd65535);
        send_write(MAP_LIMIT);         // beyond bitmap
        send_write(32'hFFFF_FFFF);
        send_write(32'd1);
        send_write(32'd2);
        send_recover(32'hFFFF_FFFF);
        send_recover(32'd1);
        send_cmd(make_cmd(ACT_IGNORED, $urandom, $urandom));
        send_flush();
        send_write(32'd0);
        wait_idle();
    endtask

    task automatic test_list_mode();
        write_cfg(CFG_USE_BITMAP, 6'd0);
        send_write(32'hFFFF_FFFE);
        send_write(32'hFFFF_FFFF);
        send_write(32'd0);             // found by log search
        send_write(MAP_LIMIT);
        send_write(32'd7);
        send_recover(32'hFFFF_FFFF);   // no wrap from all-ones to zero
        send_recover(32'd0);
        // back to bitmap without flush: list-mode saves are not marked
        write_cfg(CFG_USE_BITMAP, 6'd1);
        send_write(32'd7);
        write_cfg(CFG_NO_REG, 6'($urandom));
        send_flush();
    endtask

    task automatic test_capacity();
        write_cfg(CFG_LOG_CAPACITY, 6'd0);
        send_write(32'd10);
        write_cfg(CFG_LOG_CAPACITY, 6'd1);
        send_write(32'd11);
        write_cfg(CFG_LOG_CAPACITY, 6'd2);
        send_write(32'd12);
        send_write(32'd13);            // log full at count 1
        write_cfg(CFG_LOG_CAPACITY, 6'd63);
        send_write(32'd13);
        send_flush();
    endtask

    function automatic cmd_t random_cmd(logic [31:0] base, int span);
        cmd_t c;
        int   pick;
        c.block_pos     = $urandom;
        c.recover_limit = $urandom;
        pick = $urandom_range(99);
        if (pick < 82)
            c.action = ACT_WRITE;
        else if (pick < 94)
            c.action = ACT_RECOVER;
        else if (pick < 97)
            c.action = ACT_FLUSH;
        else
            c.action = ACT_IGNORED;
        pick = $urandom_range(99);
        if (pick < 35)
            c.block_pos = prev_rand_pos + 32'd1;
        else if (pick < 80)
            c.block_pos = base + 32'($urandom_range(0, span - 1));
        else if (pick < 88)
            c.block_pos = $urandom;
        else if (pick < 94)
            c.block_pos = 32'd65534 + 32'($urandom_range(0, 3));
        else
            c.block_pos = 32'hFFFF_FFFC + 32'($urandom_range(0, 3));
        if (c.action == ACT_WRITE)
            prev_rand_pos = c.block_pos;
        pick = $urandom_range(99);
        if (pick < 60)
            c.recover_limit = base + 32'($urandom_range(0, span));
        else if (pick < 80)
            c.recover_limit = $urandom;
        else if (pick < 90)
            c.recover_limit = 32'hFFFF_FFFF;
        else
            c.recover_limit = 32'd0;
        return c;
    endfunction

    task automatic test_random();
        bit          use_bm;
        logic [5:0]  cap;
        logic [31:0] base;
        int          span;
        int          done;
        cmd_t        c;
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0: begin use_bm = 1'b1; cap = 6'd32; base = 32'd0;           span = 40; end
                1: begin use_bm = 1'b0; cap = 6'd63; base = 32'hFFFF_FFE0;   span = 48; end
                2: begin use_bm = 1'b1; cap = 6'd7;  base = 32'd65520;       span = 24; end
                3: begin use_bm = 1'b0; cap = 6'd32; base = 32'd1000;        span = 40; end
                4: begin use_bm = 1'b1; cap = 6'd33; base = 32'($urandom_range(0, 65000));
                         span = 48; end
                default: begin use_bm = 1'b0; cap = 6'd1; base = $urandom; span = 16; end
            endcase
            write_cfg(CFG_USE_BITMAP, {5'd0, use_bm});
            write_cfg(CFG_LOG_CAPACITY, cap);
            quiet_run     = (p == 3);
            prev_rand_pos = base;
            done          = 0;
            while (done < PHASE_ITEMS)
            begin
                c = random_cmd(base, span);
                send_cmd(c);
                if (c.action != ACT_IGNORED)
                    done++;
                if (done == PHASE_ITEMS / 2 && c.action != ACT_IGNORED)
                    wait_idle();
            end
        end
        quiet_run = 1'b0;
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_defaults();
        test_list_mode();
        test_capacity();
        test_random();
        wait_idle();
        $display("Sent %0d commands and checked %0d results over %0d register writes,",
                 sent_items, checked_results, cfg_writes);
        $display("in bitmap and list mode with log capacities from 0 to 63.");
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: copy_on_write_block_tracker_top.f
src/cowbt_pkg.sv
src/cowbt_ram.sv
src/cowbt_cmp.sv
src/cowbt_ctrl.sv
src/copy_on_write_block_tracker_top.sv
tb/testbench.sv
